// ===== design/rwts_pkg.sv =====
// ----------------------------------------------------------------------------
// rwts_pkg
// Shared constants and types for the release window task selector.
// ----------------------------------------------------------------------------
package rwts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 64;
  localparam int SCORE_W   = 31;
  localparam int MISS_W    = 32;
  localparam int WEIGHT_W  = 8;
  localparam int OP_W      = 3;
  localparam int QUOT_W    = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd10;
  localparam logic [SCORE_W-1:0]  SCORE_CAP    = 31'h7FFF_FFFF;
  localparam logic [TIME_W-1:0]   TIME_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [MISS_W-1:0]   MISS_MAX     = 32'hFFFF_FFFF;

  localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_REL  = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_DL   = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK     = 3'd4;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_APPLY = 8'b0000_0010,
    S_LOAD  = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_SCORE = 8'b0001_0000,
    S_WIN   = 8'b0010_0000,
    S_SCAN  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

endpackage

// ===== design/rwts_if.sv =====
// ----------------------------------------------------------------------------
// rwts channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rwts_req_if;
  logic                              valid;
  logic                              ready;
  logic [rwts_pkg::OP_W-1:0]         op;
  logic [rwts_pkg::SLOT_W-1:0]       slot;
  logic signed [rwts_pkg::TIME_W-1:0] release_in;
  logic signed [rwts_pkg::TIME_W-1:0] deadline_in;
  logic signed [rwts_pkg::TIME_W-1:0] now;
  modport source (output valid, op, slot, release_in, deadline_in, now, input ready);
  modport sink   (input valid, op, slot, release_in, deadline_in, now, output ready);
endinterface

interface rwts_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic                               chosen;
  logic [rwts_pkg::SLOT_W-1:0]        chosen_slot;
  logic [rwts_pkg::SCORE_W-1:0]       chosen_score;
  logic                               first_run;
  logic signed [rwts_pkg::TIME_W-1:0] earliest_release;
  modport source (output valid, found, chosen, chosen_slot, chosen_score, first_run,
                  earliest_release, input ready);
  modport sink   (input valid, found, chosen, chosen_slot, chosen_score, first_run,
                  earliest_release, output ready);
endinterface

interface rwts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rwts_pkg::WEIGHT_W-1:0]  miss_weight;
  modport source (output valid, miss_weight, input ready);
  modport sink   (input valid, miss_weight, output ready);
endinterface

// ===== design/release_window_task_selector.sv =====
// ----------------------------------------------------------------------------
// release_window_task_selector
// Task slot table with add/remove/set ops and a scored pick on every tick.
// ----------------------------------------------------------------------------
// channel | dir | carries
// req     | in  | op, slot, release_in, deadline_in, now
// rsp     | out | found, chosen, chosen_slot, chosen_score, first_run, earliest_release
// cfg     | in  | miss_weight (always ready)
//
// Add/remove/set/other ops: apply step, earliest-release scan of all slots, output.
// Tick: per slot a load step; a due slot then gets a score step, preceded by the
// divider when its window is 2^32 or wider; then winner update and scan.
// The worst-case tick length is set by the shared bit-serial divider.
// req is not ready until the result sits in the output register; a stalled rsp
// holds it. Synchronous reset clears state, valid and pick flags; weight goes to 10.
// ----------------------------------------------------------------------------
module release_window_task_selector (
  input  logic         clk,
  input  logic         rst,
  rwts_req_if.sink     req,
  rwts_rsp_if.source   rsp,
  rwts_cfg_if.sink     cfg
);

  localparam int N   = rwts_pkg::MAX_TASKS;
  localparam int IW  = rwts_pkg::IDX_W;
  localparam int TW  = rwts_pkg::TIME_W;
  localparam logic [IW-1:0] LAST = IW'(N - 1);

  rwts_pkg::state_t state;

  logic [N-1:0]                  slot_valid;
  logic [N-1:0]                  never_run;
  logic [TW-1:0]                 release_time  [N];
  logic [TW-1:0]                 deadline_time [N];
  logic [rwts_pkg::MISS_W-1:0]   miss_count    [N];
  logic [rwts_pkg::WEIGHT_W-1:0] miss_weight;

  logic [rwts_pkg::OP_W-1:0]   op_q;
  logic [rwts_pkg::SLOT_W-1:0] slot_q;
  logic [TW-1:0]               rel_q, dl_q, now_q;
  logic [IW-1:0]               idx;

  logic [TW-1:0]               cur_rel, cur_dl;
  logic [rwts_pkg::MISS_W-1:0] cur_miss;
  logic                        cur_cap;

  logic                          found_r, have, first_r;
  logic [IW-1:0]                 win;
  logic [rwts_pkg::SCORE_W-1:0]  best;
  logic [TW-1:0]                 earliest;

  logic                          ov;
  logic                          o_found, o_chosen, o_first;
  logic [rwts_pkg::SLOT_W-1:0]   o_slot;
  logic [rwts_pkg::SCORE_W-1:0]  o_score;
  logic [TW-1:0]                 o_earliest;

  logic [IW-1:0]  aidx;
  logic           eligible;
  logic [TW-1:0]  span;
  logic [TW:0]    dvsr;
  logic           div_start, div_done;
  logic [rwts_pkg::QUOT_W-1:0] quot;

  logic [rwts_pkg::MISS_W+rwts_pkg::WEIGHT_W-1:0] prod;
  logic [rwts_pkg::MISS_W+rwts_pkg::WEIGHT_W:0]   total;
  logic [rwts_pkg::SCORE_W-1:0]                   score;

  assign req.ready = (state == rwts_pkg::S_IDLE);
  assign cfg.ready = 1'b1;

  assign aidx     = slot_q[IW-1:0];
  assign eligible = slot_valid[idx] && ($signed(release_time[idx]) < $signed(now_q));
  assign span     = deadline_time[idx] - release_time[idx];
  assign dvsr     = {1'b0, span} + {{TW{1'b0}}, 1'b1};
  assign div_start = (state == rwts_pkg::S_LOAD) && eligible && (dvsr[TW:32] != '0);

  rwts_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (dvsr),
    .done    (div_done),
    .quot    (quot)
  );

  always_comb begin
    prod  = cur_miss * miss_weight;
    total = {1'b0, prod} + {{(rwts_pkg::WEIGHT_W+1){1'b0}}, quot};
    if (cur_cap || (total >= {{(rwts_pkg::MISS_W+rwts_pkg::WEIGHT_W+1-rwts_pkg::SCORE_W){1'b0}},
                              rwts_pkg::SCORE_CAP})) begin
      score = rwts_pkg::SCORE_CAP;
    end else begin
      score = total[rwts_pkg::SCORE_W-1:0];
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rwts_pkg::S_IDLE;
      slot_valid  <= '0;
      miss_weight <= rwts_pkg::WEIGHT_RESET;
      ov          <= 1'b0;
      have        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        miss_weight <= cfg.miss_weight;
      end
      if ((state == rwts_pkg::S_FIN) && (!ov || rsp.ready)) begin
        ov <= 1'b1;
      end else if (ov && rsp.ready) begin
        ov <= 1'b0;
      end
      unique case (state)
        rwts_pkg::S_IDLE: begin
          if (req.valid) begin
            state <= (req.op == rwts_pkg::OP_TICK) ? rwts_pkg::S_LOAD : rwts_pkg::S_APPLY;
            have  <= 1'b0;
          end
        end
        rwts_pkg::S_APPLY: begin
          if (op_q == rwts_pkg::OP_ADD && !slot_valid[aidx]) begin
            slot_valid[aidx] <= 1'b1;
          end else if (op_q == rwts_pkg::OP_REMOVE) begin
            slot_valid[aidx] <= 1'b0;
          end
          state <= rwts_pkg::S_SCAN;
        end
        rwts_pkg::S_LOAD: begin
          if (eligible) begin
            state <= div_start ? rwts_pkg::S_DIV : rwts_pkg::S_SCORE;
          end else if (idx == LAST) begin
            state <= rwts_pkg::S_WIN;
          end
        end
        rwts_pkg::S_DIV: begin
          if (div_done) begin
            state <= rwts_pkg::S_SCORE;
          end
        end
        rwts_pkg::S_SCORE: begin
          if (score > best) begin
            have <= 1'b1;
          end
          state <= (idx == LAST) ? rwts_pkg::S_WIN : rwts_pkg::S_LOAD;
        end
        rwts_pkg::S_WIN: begin
          state <= rwts_pkg::S_SCAN;
        end
        rwts_pkg::S_SCAN: begin
          if (idx == LAST) begin
            state <= rwts_pkg::S_FIN;
          end
        end
        rwts_pkg::S_FIN: begin
          if (!ov || rsp.ready) begin
            state <= rwts_pkg::S_IDLE;
          end
        end
        default: state <= rwts_pkg::S_IDLE;
      endcase
    end
  end

  // Payload: table contents, working registers and output register
  always_ff @(posedge clk) begin
    unique case (state)
      rwts_pkg::S_IDLE: begin
        op_q    <= req.op;
        slot_q  <= req.slot;
        rel_q   <= req.release_in;
        dl_q    <= req.deadline_in;
        now_q   <= req.now;
        idx     <= '0;
        best    <= '0;
        win     <= '0;
        first_r <= 1'b0;
        found_r <= 1'b0;
      end
      rwts_pkg::S_APPLY: begin
        case (op_q)
          rwts_pkg::OP_ADD: begin
            if (!slot_valid[aidx]) begin
              release_time[aidx]  <= rel_q;
              deadline_time[aidx] <= ($signed(dl_q) < $signed(rel_q)) ? rel_q : dl_q;
              miss_count[aidx]    <= '0;
              never_run[aidx]     <= 1'b1;
              found_r             <= 1'b1;
            end
          end
          rwts_pkg::OP_REMOVE: begin
            found_r <= slot_valid[aidx];
          end
          rwts_pkg::OP_SET_REL: begin
            if (slot_valid[aidx]) begin
              release_time[aidx] <= rel_q;
              if ($signed(deadline_time[aidx]) < $signed(rel_q)) begin
                deadline_time[aidx] <= rel_q;
              end
              found_r <= 1'b1;
            end
          end
          rwts_pkg::OP_SET_DL: begin
            if (slot_valid[aidx]) begin
              deadline_time[aidx] <= dl_q;
              if ($signed(dl_q) < $signed(release_time[aidx])) begin
                release_time[aidx] <= dl_q;
              end
              found_r <= 1'b1;
            end
          end
          default: ;
        endcase
        idx      <= '0;
        earliest <= rwts_pkg::TIME_MAX;
      end
      rwts_pkg::S_LOAD: begin
        cur_miss <= miss_count[idx];
        cur_cap  <= (dvsr[TW:32] == '0);
        if (!eligible && idx != LAST) begin
          idx <= idx + 1'b1;
        end
      end
      rwts_pkg::S_DIV: ;
      rwts_pkg::S_SCORE: begin
        if (cur_miss != rwts_pkg::MISS_MAX) begin
          miss_count[idx] <= cur_miss + 1'b1;
        end
        if (score > best) begin
          best <= score;
          win  <= idx;
        end
        if (idx != LAST) begin
          idx <= idx + 1'b1;
        end
      end
      rwts_pkg::S_WIN: begin
        if (have) begin
          first_r         <= never_run[win];
          miss_count[win] <= '0;
          never_run[win]  <= 1'b0;
        end
        idx      <= '0;
        earliest <= rwts_pkg::TIME_MAX;
      end
      rwts_pkg::S_SCAN: begin
        if (slot_valid[idx] && ($signed(release_time[idx]) < $signed(earliest))) begin
          earliest <= release_time[idx];
        end
        if (idx != LAST) begin
          idx <= idx + 1'b1;
        end
      end
      rwts_pkg::S_FIN: begin
        if (!ov || rsp.ready) begin
          o_found    <= found_r;
          o_chosen   <= have;
          o_slot     <= have ? rwts_pkg::SLOT_W'(win) : '0;
          o_score    <= have ? best : '0;
          o_first    <= have && first_r;
          o_earliest <= earliest;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid            = ov;
  assign rsp.found            = o_found;
  assign rsp.chosen           = o_chosen;
  assign rsp.chosen_slot      = o_slot;
  assign rsp.chosen_score     = o_score;
  assign rsp.first_run        = o_first;
  assign rsp.earliest_release = o_earliest;

`ifndef SYNTHESIS
  a_chosen_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.chosen |-> rsp.chosen_score != '0)
    else $error("chosen task with zero score");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.chosen |-> rsp.chosen_slot == '0 && !rsp.first_run)
    else $error("selection fields set without a pick");

  a_found_xor_chosen: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.found && rsp.chosen))
    else $error("found and chosen both set");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == rwts_pkg::S_DIV)
    else $error("divider started outside divide phase");
`endif

endmodule

// ===== design/rwts_div.sv =====
// ----------------------------------------------------------------------------
// rwts_div
// Bit-serial divider: floor((2^64-1)/d) for d >= 2^32, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rwts_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rwts_pkg::TIME_W:0]       divisor,
  output logic                            done,
  output logic [rwts_pkg::QUOT_W-1:0]     quot
);

  logic [rwts_pkg::TIME_W:0]   rem;
  logic [rwts_pkg::TIME_W+1:0] trial;
  logic [rwts_pkg::TIME_W+1:0] diff;
  logic                        ge;
  logic                        busy;
  logic [$clog2(rwts_pkg::QUOT_W)-1:0] cnt;

  // The upper half of the all-ones dividend is already below the divisor,
  // so only the low 32 dividend bits (all ones) are shifted in.
  assign trial = {rem, 1'b1};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == {$clog2(rwts_pkg::QUOT_W){1'b1}}) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {{(rwts_pkg::TIME_W+1-rwts_pkg::QUOT_W){1'b0}}, {rwts_pkg::QUOT_W{1'b1}}};
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[rwts_pkg::TIME_W:0] : trial[rwts_pkg::TIME_W:0];
      quot <= {quot[rwts_pkg::QUOT_W-2:0], ge};
    end
  end

endmodule

// ===== sim/rwts_checker.sv =====
// ----------------------------------------------------------------------------
// rwts_checker
// Watches the request, response and configuration channels of the task
// selector, predicts each response from its own copy of the slot table and
// compares the responses field by field in order.
// ----------------------------------------------------------------------------
module rwts_checker (
  input  logic     clk,
  input  logic     rst,
  rwts_req_if.sink req_mon,
  rwts_rsp_if.sink rsp_mon,
  rwts_cfg_if.sink cfg_mon,
  output int       fail_count,
  output int       pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                               found;
    logic                               chosen;
    logic [rwts_pkg::SLOT_W-1:0]        chosen_slot;
    logic [rwts_pkg::SCORE_W-1:0]       chosen_score;
    logic                               first_run;
    logic signed [rwts_pkg::TIME_W-1:0] earliest_release;
  } pick_t;

  pick_t pick_q[$];

  logic                               occ[rwts_pkg::MAX_TASKS];
  logic signed [rwts_pkg::TIME_W-1:0] rel_t[rwts_pkg::MAX_TASKS];
  logic signed [rwts_pkg::TIME_W-1:0] dl_t[rwts_pkg::MAX_TASKS];
  logic [rwts_pkg::MISS_W-1:0]        misses[rwts_pkg::MAX_TASKS];
  logic                               fresh[rwts_pkg::MAX_TASKS];
  logic [rwts_pkg::WEIGHT_W-1:0]      weight;

  assign pending_count = pick_q.size();

  function automatic logic [63:0] slot_score(int i);
    logic [63:0] span;
    logic [63:0] win;
    logic [63:0] total;
    span = dl_t[i] - rel_t[i];
    win = (span == 64'hFFFF_FFFF_FFFF_FFFF) ? 64'd0 : (64'hFFFF_FFFF_FFFF_FFFF / (span + 64'd1));
    if (win >= 64'(rwts_pkg::SCORE_CAP)) return 64'(rwts_pkg::SCORE_CAP);
    total = win + 64'(misses[i]) * 64'(weight);
    return (total > 64'(rwts_pkg::SCORE_CAP)) ? 64'(rwts_pkg::SCORE_CAP) : total;
  endfunction

  task automatic predict_pick(input logic [rwts_pkg::OP_W-1:0] op,
                              input logic [rwts_pkg::SLOT_W-1:0] s,
                              input logic signed [rwts_pkg::TIME_W-1:0] r,
                              input logic signed [rwts_pkg::TIME_W-1:0] d,
                              input logic signed [rwts_pkg::TIME_W-1:0] t);
    pick_t p;
    logic [63:0] best;
    logic [63:0] sc;
    int win;
    p = '0;
    best = 0;
    win = -1;
    case (op)
      rwts_pkg::OP_ADD: begin
        if (!occ[s]) begin
          occ[s] = 1; rel_t[s] = r; dl_t[s] = (d < r) ? r : d;
          misses[s] = 0; fresh[s] = 1; p.found = 1;
        end
      end
      rwts_pkg::OP_REMOVE: begin
        if (occ[s]) begin occ[s] = 0; p.found = 1; end
      end
      rwts_pkg::OP_SET_REL: begin
        if (occ[s]) begin
          rel_t[s] = r;
          if (dl_t[s] < r) dl_t[s] = r;
          p.found = 1;
        end
      end
      rwts_pkg::OP_SET_DL: begin
        if (occ[s]) begin
          dl_t[s] = d;
          if (d < rel_t[s]) rel_t[s] = d;
          p.found = 1;
        end
      end
      rwts_pkg::OP_TICK: begin
        for (int i = 0; i < rwts_pkg::MAX_TASKS; i++) begin
          if (occ[i] && rel_t[i] < t) begin
            sc = slot_score(i);
            if (misses[i] != rwts_pkg::MISS_MAX) misses[i]++;
            if (sc > best) begin best = sc; win = i; end
          end
        end
        if (win >= 0) begin
          p.chosen = 1; p.chosen_slot = rwts_pkg::SLOT_W'(win);
          p.chosen_score = rwts_pkg::SCORE_W'(best); p.first_run = fresh[win];
          misses[win] = 0; fresh[win] = 0;
        end
      end
      default: ;
    endcase
    p.earliest_release = rwts_pkg::TIME_MAX;
    for (int i = 0; i < rwts_pkg::MAX_TASKS; i++)
      if (occ[i] && rel_t[i] < p.earliest_release) p.earliest_release = rel_t[i];
    pick_q.push_back(p);
  endtask

  always @(posedge clk) begin
    pick_t e;
    pick_t a;
    if (rst) begin
      for (int i = 0; i < rwts_pkg::MAX_TASKS; i++) begin
        occ[i] = 0; misses[i] = 0; fresh[i] = 0; rel_t[i] = 0; dl_t[i] = 0;
      end
      weight = rwts_pkg::WEIGHT_RESET;
      fail_count <= 0;
      pick_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) weight = cfg_mon.miss_weight;
      if (rsp_mon.valid && rsp_mon.ready) begin
        a = '{rsp_mon.found, rsp_mon.chosen, rsp_mon.chosen_slot, rsp_mon.chosen_score,
              rsp_mon.first_run, rsp_mon.earliest_release};
        if (pick_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected response %p", a);
          fail_count <= fail_count + 1;
        end else begin
          e = pick_q.pop_front();
          if (a !== e) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", e, a);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        predict_pick(req_mon.op, req_mon.slot, req_mon.release_in, req_mon.deadline_in,
                     req_mon.now);
    end
  end
endmodule

// ===== sim/tb_release_window_task_selector.sv =====
// ----------------------------------------------------------------------------
// tb_release_window_task_selector
// Directed and random slot operations and ticks with random idling on both
// channels and several miss weights; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_release_window_task_selector;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  int   fail_count;
  int   pending_count;

  rwts_req_if req ();
  rwts_rsp_if rsp ();
  rwts_cfg_if cfg ();

  release_window_task_selector uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));
  rwts_checker chk (.clk(clk), .rst(rst), .req_mon(req), .rsp_mon(rsp), .cfg_mon(cfg),
                    .fail_count(fail_count), .pending_count(pending_count));

  always begin #1 clk = 1; #1 clk = 0; end

  initial begin
    req.valid = 0; req.op = 0; req.slot = 0; req.release_in = 0; req.deadline_in = 0;
    req.now = 0; rsp.ready = 0; cfg.valid = 0; cfg.miss_weight = 0;
  end

  function automatic int gap_len();
    if ($urandom_range(9) < 5) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(60, 20);
    return $urandom_range(3);
  endfunction

  // sink side: random stalls
  initial begin
    int g;
    @(posedge clk);
    while (1) begin
      g = gap_len();
      if (g > 0) begin
        rsp.ready <= 0;
        repeat (g) @(posedge clk);
      end
      rsp.ready <= 1;
      @(posedge clk);
    end
  end

  function automatic logic [63:0] rand_time(int mode);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case (mode)
      0: return v;
      1: return 64'(signed'(32'($urandom_range(200)) - 100));
      default: return {{40{v[23]}}, v[23:0]};
    endcase
  endfunction

  task automatic send(input logic [rwts_pkg::OP_W-1:0] op, input logic [3:0] s,
                      input logic [63:0] r, input logic [63:0] d, input logic [63:0] t);
    req.valid <= 1; req.op <= op; req.slot <= s;
    req.release_in <= r; req.deadline_in <= d; req.now <= t;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    req.valid <= 0;
    @(posedge clk);
    repeat (gap_len()) @(posedge clk);
  endtask

  task automatic set_weight(input logic [rwts_pkg::WEIGHT_W-1:0] w);
    int guard;
    guard = 0;
    while (pending_count != 0 && guard < 200000) begin @(posedge clk); guard++; end
    repeat (20) @(posedge clk);
    cfg.valid <= 1; cfg.miss_weight <= w;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
  endtask

  localparam logic [63:0] TMIN = 64'h8000_0000_0000_0000;

  initial begin
    logic [2:0] op;
    int m;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed
    send(rwts_pkg::OP_TICK, 0, 0, 0, 0);
    send(rwts_pkg::OP_REMOVE, 3, 0, 0, 0);
    send(rwts_pkg::OP_SET_REL, 3, 5, 0, 0);
    send(rwts_pkg::OP_ADD, 0, TMIN, rwts_pkg::TIME_MAX, 0);      // full-range window
    send(rwts_pkg::OP_ADD, 0, 1, 2, 0);                          // occupied slot
    send(rwts_pkg::OP_ADD, 1, 100, 50, 0);                       // deadline raised
    send(rwts_pkg::OP_ADD, 2, 10, 10, 0);
    send(rwts_pkg::OP_ADD, 15, rwts_pkg::TIME_MAX, rwts_pkg::TIME_MAX, 0);
    send(rwts_pkg::OP_ADD, 4, -64'sd5, 64'h0000_0002_0000_0000, 0);
    send(rwts_pkg::OP_ADD, 5, -64'sd5, 64'h0000_0002_0000_0000, 0);  // tie with slot 4
    send(rwts_pkg::OP_TICK, 0, 0, 0, 1000);
    send(rwts_pkg::OP_TICK, 0, 0, 0, rwts_pkg::TIME_MAX);
    send(rwts_pkg::OP_TICK, 0, 0, 0, TMIN);
    send(rwts_pkg::OP_SET_REL, 2, 500, 0, 0);                    // deadline pushed
    send(rwts_pkg::OP_SET_DL, 1, 0, -64'sd7, 0);                 // release pulled
    send(rwts_pkg::OP_TICK, 0, 0, 0, rwts_pkg::TIME_MAX);
    send(3'd5, 7, 0, 0, 0);
    send(3'd6, 0, 0, 0, 0);
    send(3'd7, 15, rwts_pkg::TIME_MAX, TMIN, TMIN);
    send(rwts_pkg::OP_REMOVE, 0, 0, 0, 0);
    send(rwts_pkg::OP_TICK, 0, 0, 0, rwts_pkg::TIME_MAX);
    set_weight(8'd255);
    for (int k = 0; k < 4; k++) send(rwts_pkg::OP_TICK, 0, 0, 0, rwts_pkg::TIME_MAX);
    // random phases with different weights
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: set_weight(8'd0);
        2: set_weight(8'($urandom_range(255)));
        3: set_weight(8'd255);
        4: set_weight(8'd10);
        default: ;
      endcase
      for (int n = 0; n < 205; n++) begin
        m = $urandom_range(2);
        case ($urandom_range(19))
          0, 1, 2, 3: op = rwts_pkg::OP_ADD;
          4, 5: op = rwts_pkg::OP_REMOVE;
          6, 7: op = rwts_pkg::OP_SET_REL;
          8, 9: op = rwts_pkg::OP_SET_DL;
          19: op = 3'($urandom_range(7, 5));
          default: op = rwts_pkg::OP_TICK;
        endcase
        send(op, 4'($urandom_range(15)), rand_time(m), rand_time(m), rand_time(m));
      end
    end
    while (pending_count != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== release_window_task_selector.f =====
design/rwts_pkg.sv
design/rwts_if.sv
design/rwts_div.sv
design/release_window_task_selector.sv
sim/rwts_checker.sv
sim/tb_release_window_task_selector.sv
